// ===== rtl/bnms_pkg.sv =====
// ----------------------------------------------------------------------------
// bnms_pkg
// Shared types and constants for the box non-maximum suppression block.
// ----------------------------------------------------------------------------
package bnms_pkg;

    localparam int CoordBits = 16;
    localparam int ScoreW    = 16;
    localparam int IdxW      = 6;
    localparam int Csh       = (CoordBits > 16) ? CoordBits - 16 : 0;
    localparam int RedW      = CoordBits - Csh;
    localparam int DivSteps  = 16;
    // diff stage, product stage, union stage, divider steps, decision stage
    localparam int PipeDepth = 3 + DivSteps + 1;

    localparam logic [ScoreW-1:0] ScoreDead = ScoreW'(66);

    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CfgOverlapLimit = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgScoreFloor   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgSoftMode     = 2'd2;

    localparam logic [15:0] OverlapLimitReset = 16'd29491;
    localparam logic [15:0] ScoreFloorReset   = 16'd39322;

    typedef struct packed {
        logic signed [CoordBits-1:0] left_edge;
        logic signed [CoordBits-1:0] top_edge;
        logic signed [CoordBits-1:0] right_edge;
        logic signed [CoordBits-1:0] bottom_edge;
        logic        [ScoreW-1:0]    confidence;
        logic                        final_box;
    } t_in;

    typedef struct packed {
        logic signed [CoordBits-1:0] kept_left;
        logic signed [CoordBits-1:0] kept_top;
        logic signed [CoordBits-1:0] kept_right;
        logic signed [CoordBits-1:0] kept_bottom;
        logic        [ScoreW-1:0]    kept_score;
        logic        [IdxW-1:0]      arrival_index;
        logic                        run_end;
        logic                        none_kept;
        logic                        overflowed;
    } t_out;

    typedef struct packed {
        logic [CoordBits-1:0] left;
        logic [CoordBits-1:0] top;
        logic [CoordBits-1:0] right;
        logic [CoordBits-1:0] bottom;
        logic [ScoreW-1:0]    score;
        logic [IdxW-1:0]      idx;
    } t_entry;

    typedef struct packed {
        logic load;
        logic rotate;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic [15:0] overlap_limit;
        logic [15:0] score_floor;
        logic        soft_mode;
    } t_cfg;

endpackage

// ===== rtl/bnms_cell.sv =====
// ----------------------------------------------------------------------------
// bnms_cell
// One slot of the box ring: sorted insertion while loading, rotation while
// suppressing.
// ----------------------------------------------------------------------------
module bnms_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bnms_pkg::t_cell_ctl i_ctl,
    input  bnms_pkg::t_entry    i_new,
    input  logic                i_prev_keep,
    input  logic                i_left_vld,
    input  bnms_pkg::t_entry    i_left,
    input  logic                i_right_vld,
    input  bnms_pkg::t_entry    i_right,
    output logic                o_vld,
    output bnms_pkg::t_entry    o_ent,
    output logic                o_keep
);

    logic             r_vld;
    bnms_pkg::t_entry r_ent;

    // a slot keeps its box when that box ranks at or ahead of the new one
    assign o_keep = r_vld && (r_ent.score >= i_new.score);
    assign o_vld  = r_vld;
    assign o_ent  = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctl.load && !o_keep) begin
            r_vld <= i_prev_keep ? 1'b1 : i_left_vld;
        end else if (i_ctl.rotate) begin
            r_vld <= i_right_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && !o_keep) begin
            r_ent <= i_prev_keep ? i_new : i_left;
        end else if (i_ctl.rotate) begin
            r_ent <= i_right;
        end
    end

endmodule

// ===== rtl/bnms_iou_pipe.sv =====
// ----------------------------------------------------------------------------
// bnms_iou_pipe
// Pipelined IoU against the current keeper box plus score update; forms the
// tail of the box ring.
// ----------------------------------------------------------------------------
module bnms_iou_pipe (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_clear,
    input  bnms_pkg::t_cfg   i_cfg,
    input  bnms_pkg::t_entry i_keeper,
    input  logic             i_vld,
    input  logic             i_en,
    input  bnms_pkg::t_entry i_ent,
    output logic             o_vld,
    output bnms_pkg::t_entry o_ent
);

    localparam int Rw  = bnms_pkg::RedW;
    localparam int Pw  = 2 * Rw;
    localparam int Aw  = 2 * (Rw + 1);
    localparam int Uw  = Aw + 2;
    localparam int Dn  = bnms_pkg::DivSteps;
    localparam int Pd  = bnms_pkg::PipeDepth;
    localparam int ScoreWc = bnms_pkg::ScoreW + Dn + 1;

    function automatic logic [Rw-1:0] red(input logic [bnms_pkg::CoordBits-1:0] v);
        logic [bnms_pkg::CoordBits-1:0] t;
        begin
            t   = v ^ {1'b1, {(bnms_pkg::CoordBits-1){1'b0}}};
            red = Rw'(t >> bnms_pkg::Csh);
        end
    endfunction

    logic             r_vld [Pd];
    logic             r_en  [Pd];
    bnms_pkg::t_entry r_ent [Pd];

    logic [Rw-1:0]        r_w, r_h;
    logic signed [Rw:0]   r_dxa, r_dya, r_dxb, r_dyb;
    logic [Pw-1:0]        r_inter;
    logic signed [Aw-1:0] r_aa, r_ab;
    logic [Uw-1:0]        r_rem [Dn+1];
    logic [Uw-1:0]        r_den [Dn+1];
    logic [Dn-1:0]        r_quo [Dn+1];
    logic                 r_zero [Dn+1];
    logic                 r_sat  [Dn+1];

    // overlap and box extents
    logic [Rw-1:0] kl, kt, kr, kb, bl, bt, br, bb;
    logic [Rw-1:0] mnr, mxl, mnb, mxt;
    logic [Rw:0]   dw, dh;

    always_comb begin
        kl  = red(i_keeper.left);
        kt  = red(i_keeper.top);
        kr  = red(i_keeper.right);
        kb  = red(i_keeper.bottom);
        bl  = red(i_ent.left);
        bt  = red(i_ent.top);
        br  = red(i_ent.right);
        bb  = red(i_ent.bottom);
        mnr = (kr < br) ? kr : br;
        mxl = (kl > bl) ? kl : bl;
        mnb = (kb < bb) ? kb : bb;
        mxt = (kt > bt) ? kt : bt;
        dw  = {1'b0, mnr} - {1'b0, mxl};
        dh  = {1'b0, mnb} - {1'b0, mxt};
    end

    // union and early outcomes
    logic signed [Uw-1:0] uni;
    logic                 uni_zero;
    logic                 uni_sat;

    always_comb begin
        uni      = Uw'(r_aa) + Uw'(r_ab) - $signed({2'b00, Aw'(r_inter)});
        uni_zero = (uni <= 0);
        uni_sat  = !uni_zero && ($signed(Uw'(r_inter)) >= uni);
    end

    // restoring divider steps, one quotient bit each
    logic [Uw-1:0] rem2 [Dn];
    logic          ge   [Dn];

    always_comb begin
        for (int k = 0; k < Dn; k++) begin
            rem2[k] = {r_rem[k][Uw-2:0], 1'b0};
            ge[k]   = (rem2[k] >= r_den[k]);
        end
    end

    // decision and soft decay
    logic [Dn:0]           q;
    logic                  hit;
    logic [ScoreWc-1:0]    prod;
    logic [bnms_pkg::ScoreW-1:0] decayed;
    logic [bnms_pkg::ScoreW-1:0] new_score;
    bnms_pkg::t_entry      upd_ent;

    always_comb begin
        if (r_zero[Dn]) begin
            q = '0;
        end else if (r_sat[Dn]) begin
            q = {1'b1, {Dn{1'b0}}};
        end else begin
            q = {1'b0, r_quo[Dn]};
        end
        hit     = r_en[Pd-2] && (q > {1'b0, i_cfg.overlap_limit});
        prod    = ScoreWc'(r_ent[Pd-2].score) * ScoreWc'({1'b1, {Dn{1'b0}}} - q);
        decayed = prod[Dn +: bnms_pkg::ScoreW];
        if (!hit) begin
            new_score = r_ent[Pd-2].score;
        end else if (i_cfg.soft_mode && (decayed >= i_cfg.score_floor)) begin
            new_score = decayed;
        end else begin
            new_score = '0;
        end
        upd_ent       = r_ent[Pd-2];
        upd_ent.score = new_score;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Pd; k++) r_vld[k] <= 1'b0;
        end else if (i_clear) begin
            for (int k = 0; k < Pd; k++) r_vld[k] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < Pd; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_en[0]  <= i_en;
            r_ent[0] <= i_ent;
            for (int k = 1; k < Pd; k++) begin
                r_en[k] <= r_en[k-1];
            end
            for (int k = 1; k < Pd - 1; k++) begin
                r_ent[k] <= r_ent[k-1];
            end
            r_ent[Pd-1] <= upd_ent;

            r_w   <= dw[Rw] ? '0 : dw[Rw-1:0];
            r_h   <= dh[Rw] ? '0 : dh[Rw-1:0];
            r_dxa <= $signed({1'b0, kr}) - $signed({1'b0, kl});
            r_dya <= $signed({1'b0, kb}) - $signed({1'b0, kt});
            r_dxb <= $signed({1'b0, br}) - $signed({1'b0, bl});
            r_dyb <= $signed({1'b0, bb}) - $signed({1'b0, bt});

            r_inter <= r_w * r_h;
            r_aa    <= r_dxa * r_dya;
            r_ab    <= r_dxb * r_dyb;

            r_rem[0]  <= Uw'(r_inter);
            r_den[0]  <= uni;
            r_quo[0]  <= '0;
            r_zero[0] <= uni_zero;
            r_sat[0]  <= uni_sat;
            for (int k = 0; k < Dn; k++) begin
                r_rem[k+1]  <= ge[k] ? (rem2[k] - r_den[k]) : rem2[k];
                r_den[k+1]  <= r_den[k];
                r_quo[k+1]  <= {r_quo[k][Dn-2:0], ge[k]};
                r_zero[k+1] <= r_zero[k];
                r_sat[k+1]  <= r_sat[k];
            end
        end
    end

    assign o_vld = r_vld[Pd-1];
    assign o_ent = r_ent[Pd-1];

endmodule

// ===== rtl/box_non_max_suppression.sv =====
// Loading: one box per cycle, inserted in score order into the cell ring if it has room.
// Suppression: one pass per loaded box; a live keeper takes a select step, then
// one ring turn through the 20-stage IoU pipeline plus one step, a dead one only
// its select step; a final step closes the set.
// Results are strobed during the passes and at the end; the receiver cannot stall.
// Synchronous active-low reset clears the ring, counters and config to defaults.
// ----------------------------------------------------------------------------
// box_non_max_suppression
// Greedy IoU non-maximum suppression over a ring of box cells.
// ----------------------------------------------------------------------------
module box_non_max_suppression #(
    parameter int MAX_BOXES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  bnms_pkg::t_in                       i_item,
    output logic                                o_busy,
    output logic                                o_res_valid,
    output bnms_pkg::t_out                      o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bnms_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [15:0]                         i_cfg_data
);

    localparam int CntW  = $clog2(MAX_BOXES + 1);
    localparam int Ring  = MAX_BOXES + bnms_pkg::PipeDepth;
    localparam int CycW  = $clog2(Ring + 1);
    localparam int SumW  = CycW + CntW;

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_SEL  = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       r_state;
    logic [CntW-1:0]  r_count;
    logic [CntW-1:0]  r_pass;
    logic [CycW-1:0]  r_cyc;
    logic             r_drop;
    bnms_pkg::t_cfg   r_cfg;
    bnms_pkg::t_entry r_keeper;
    bnms_pkg::t_entry r_pend;
    logic             r_has_pend;
    logic             r_res_valid;
    bnms_pkg::t_out   r_result;

    logic             c_vld  [MAX_BOXES];
    bnms_pkg::t_entry c_ent  [MAX_BOXES];
    logic             c_keep [MAX_BOXES];

    logic             p_vld;
    bnms_pkg::t_entry p_ent;

    logic               accept;
    logic               head_alive;
    logic               pipe_en;
    bnms_pkg::t_cell_ctl ctl;
    bnms_pkg::t_entry   new_ent;

    assign accept      = i_start && !o_busy;
    assign o_busy      = (r_state != S_LOAD);
    // settings change only while not busy, never during suppression
    assign o_cfg_ready = !o_busy;
    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

    assign head_alive = c_vld[0] && (c_ent[0].score >= bnms_pkg::ScoreDead);

    always_comb begin
        new_ent.left   = i_item.left_edge;
        new_ent.top    = i_item.top_edge;
        new_ent.right  = i_item.right_edge;
        new_ent.bottom = i_item.bottom_edge;
        new_ent.score  = i_item.confidence;
        new_ent.idx    = bnms_pkg::IdxW'(r_count);
    end

    always_comb begin
        ctl.load   = accept && (r_count < CntW'(MAX_BOXES));
        ctl.clear  = (r_state == S_DONE);
        ctl.rotate = (r_state == S_RUN) ||
                     ((r_state == S_SEL) && (r_pass != r_count) && !head_alive);
        // only boxes after the keeper in sorted order are tested
        pipe_en    = (r_state == S_RUN) && head_alive && (r_cyc != '0) &&
                     ((SumW'(r_cyc) + SumW'(r_pass)) < SumW'(r_count));
    end

    for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
        bnms_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_new       (new_ent),
            .i_prev_keep ((g == 0) ? 1'b1 : c_keep[(g == 0) ? 0 : g-1]),
            .i_left_vld  ((g == 0) ? 1'b0 : c_vld[(g == 0) ? 0 : g-1]),
            .i_left      ((g == 0) ? new_ent : c_ent[(g == 0) ? 0 : g-1]),
            .i_right_vld ((g == MAX_BOXES-1) ? p_vld :
                          c_vld[(g == MAX_BOXES-1) ? g : g+1]),
            .i_right     ((g == MAX_BOXES-1) ? p_ent :
                          c_ent[(g == MAX_BOXES-1) ? g : g+1]),
            .o_vld       (c_vld[g]),
            .o_ent       (c_ent[g]),
            .o_keep      (c_keep[g])
        );
    end

    bnms_iou_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (ctl.rotate),
        .i_clear  (ctl.clear),
        .i_cfg    (r_cfg),
        .i_keeper (r_keeper),
        .i_vld    (c_vld[0]),
        .i_en     (pipe_en),
        .i_ent    (c_ent[0]),
        .o_vld    (p_vld),
        .o_ent    (p_ent)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overlap_limit <= bnms_pkg::OverlapLimitReset;
            r_cfg.score_floor   <= bnms_pkg::ScoreFloorReset;
            r_cfg.soft_mode     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bnms_pkg::CfgOverlapLimit: r_cfg.overlap_limit <= i_cfg_data;
                bnms_pkg::CfgScoreFloor:   r_cfg.score_floor   <= i_cfg_data;
                bnms_pkg::CfgSoftMode:     r_cfg.soft_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= (r_state == S_DONE) ||
                           ((r_state == S_SEL) && (r_pass != r_count) && head_alive &&
                            r_has_pend);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_pass      <= '0;
            r_cyc       <= '0;
            r_drop      <= 1'b0;
            r_has_pend  <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (ctl.load) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_item.final_box) begin
                            r_pass  <= '0;
                            r_state <= S_SEL;
                        end
                    end
                end
                S_SEL: begin
                    if (r_pass == r_count) begin
                        r_state <= S_DONE;
                    end else if (head_alive) begin
                        r_keeper   <= c_ent[0];
                        r_pend     <= c_ent[0];
                        r_has_pend <= 1'b1;
                        r_cyc      <= '0;
                        r_state    <= S_RUN;
                        if (r_has_pend) begin
                            r_result.kept_left     <= r_pend.left;
                            r_result.kept_top      <= r_pend.top;
                            r_result.kept_right    <= r_pend.right;
                            r_result.kept_bottom   <= r_pend.bottom;
                            r_result.kept_score    <= r_pend.score;
                            r_result.arrival_index <= r_pend.idx;
                            r_result.run_end       <= 1'b0;
                            r_result.none_kept     <= 1'b0;
                            r_result.overflowed    <= r_drop;
                        end
                    end else begin
                        r_pass <= r_pass + 1'b1;
                    end
                end
                S_RUN: begin
                    // one full ring turn plus one step leaves the next box at the head
                    if (r_cyc == CycW'(Ring)) begin
                        r_pass  <= r_pass + 1'b1;
                        r_state <= S_SEL;
                    end else begin
                        r_cyc <= r_cyc + 1'b1;
                    end
                end
                S_DONE: begin
                    if (r_has_pend) begin
                        r_result.kept_left     <= r_pend.left;
                        r_result.kept_top      <= r_pend.top;
                        r_result.kept_right    <= r_pend.right;
                        r_result.kept_bottom   <= r_pend.bottom;
                        r_result.kept_score    <= r_pend.score;
                        r_result.arrival_index <= r_pend.idx;
                        r_result.none_kept     <= 1'b0;
                    end else begin
                        r_result.kept_left     <= '0;
                        r_result.kept_top      <= '0;
                        r_result.kept_right    <= '0;
                        r_result.kept_bottom   <= '0;
                        r_result.kept_score    <= '0;
                        r_result.arrival_index <= '0;
                        r_result.none_kept     <= 1'b1;
                    end
                    r_result.run_end    <= 1'b1;
                    r_result.overflowed <= r_drop;
                    r_has_pend <= 1'b0;
                    r_count    <= '0;
                    r_drop     <= 1'b0;
                    r_state    <= S_LOAD;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MAX_BOXES))
        else $error("box count above capacity");

    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_pass < r_count))
        else $error("suppression pass beyond loaded boxes");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.none_kept) |-> o_result.run_end)
        else $error("empty result not marked as end of set");

    a_final_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.final_box) |=> o_busy)
        else $error("final box did not start suppression");
`endif

endmodule
